// File: rtl/core/ddodo_pkg.sv
// Shared types, constants and the arctangent table of the odometry block.
package ddodo_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_WHEEL_BASE = 2'd1;

  localparam logic [31:0] DIST_PER_TICK_RESET = 32'd368060;
  localparam logic [31:0] INV_WHEEL_BASE_RESET = 32'd74565404;
  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
  localparam logic [31:0] CORDIC_GAIN_INV = 32'h9B74EDA8;

  // Datapath widths: signed wheel distance in Q.24, CORDIC vector, CORDIC angle.
  localparam int DIST_W = 57;
  localparam int VEC_W = 61;
  localparam int ANG_W = 34;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ddodo_in_if.sv
// Input channel carrying one sample of both wheel encoder counts.
interface ddodo_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] right_count;
  logic signed [31:0] left_count;

  modport source (output valid, right_count, left_count, input ready);
  modport sink (input valid, right_count, left_count, output ready);
endinterface

// File: rtl/core/ddodo_out_if.sv
// Output channel carrying one pose item.
interface ddodo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0] heading_angle;

  modport source (output valid, pose_x, pose_y, heading_angle, input ready);
  modport sink (input valid, pose_x, pose_y, heading_angle, output ready);
endinterface

// File: rtl/core/differential_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
//
// Each item on the sample channel carries the absolute right and left encoder
// counts. The block forms wrapping tick deltas against the counts of the
// previous item, scales them to wheel distances, rotates the centre distance
// through the heading held before the item with an iterative CORDIC, advances
// the heading by the distance difference times the inverse wheel base, and
// puts out one pose item: x and y in saturating Q16.16 metres and the heading
// as a 32-bit binary angle. From acceptance to the pose register, an item
// first drives the single shared 32 by 32 multiplier through its nine
// products, then runs the rotator for CORDIC_STEPS micro-rotations, and
// then loads and hands over the result. The block accepts one item at a
// time; a finished pose waits in the output register while the next sample
// is taken. Configuration writes on cfg_we/cfg_index/cfg_data set the
// distance per tick (index 0) and the inverse wheel base (index 1); other
// indexes are ignored.
module differential_drive_odometry
  import ddodo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  ddodo_in_if.sink sample,
  ddodo_out_if.source pose,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_ROT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  // Multiplier operations, issued in this order; each product is used in the
  // cycle after it is issued.
  localparam logic [3:0] OP_RIGHT = 4'd0;
  localparam logic [3:0] OP_LEFT = 4'd1;
  localparam logic [3:0] OP_TURN = 4'd2;
  localparam logic [3:0] OP_GAIN_LO = 4'd3;
  localparam logic [3:0] OP_GAIN_HI = 4'd4;
  localparam logic [3:0] OP_HEAD_00 = 4'd5;
  localparam logic [3:0] OP_HEAD_01 = 4'd6;
  localparam logic [3:0] OP_HEAD_10 = 4'd7;
  localparam logic [3:0] OP_HEAD_11 = 4'd8;
  localparam logic [3:0] OP_LAST = 4'd9;

  logic [1:0] state;
  logic [3:0] mc;

  logic [31:0] distance_per_tick;
  logic [31:0] inverse_wheel_base;
  logic [31:0] prev_right;
  logic [31:0] prev_left;
  logic signed [31:0] pos_x_acc;
  logic signed [31:0] pos_y_acc;
  logic [31:0] heading_acc;

  logic [31:0] cur_right;
  logic [31:0] cur_left;
  logic signed [DIST_W-1:0] dist_r;
  logic signed [DIST_W-1:0] dist_l;
  logic [61:0] turn_k;
  logic [31:0] x0_lo;
  vec_t x0;
  logic [79:0] head_acc80;
  logic [1:0] quad;
  logic [63:0] prod;

  // Tick deltas, wrapped to COUNT_BITS.
  logic [31:0] raw_r;
  logic [31:0] raw_l;
  logic [COUNT_BITS-1:0] tick_r;
  logic [COUNT_BITS-1:0] tick_l;
  logic [COUNT_BITS-1:0] tmag_r;
  logic [COUNT_BITS-1:0] tmag_l;

  assign raw_r = cur_right - prev_right;
  assign raw_l = cur_left - prev_left;
  assign tick_r = raw_r[COUNT_BITS-1:0];
  assign tick_l = raw_l[COUNT_BITS-1:0];
  assign tmag_r = tick_r[COUNT_BITS-1] ? -tick_r : tick_r;
  assign tmag_l = tick_l[COUNT_BITS-1] ? -tick_l : tick_l;

  // Centre distance (floor of the half sum) and distance difference.
  logic signed [DIST_W:0] dist_sum;
  logic signed [DIST_W:0] dist_diff;
  logic signed [DIST_W-1:0] centre;
  logic [DIST_W-1:0] centre_mag;
  logic [DIST_W:0] diff_mag;

  assign dist_sum = {dist_r[DIST_W-1], dist_r} + {dist_l[DIST_W-1], dist_l};
  assign dist_diff = {dist_r[DIST_W-1], dist_r} - {dist_l[DIST_W-1], dist_l};
  assign centre = dist_sum[DIST_W:1];
  assign centre_mag = centre[DIST_W-1] ? -centre : centre;
  assign diff_mag = dist_diff[DIST_W] ? -dist_diff : dist_diff;

  // Shared multiplier operand selection.
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mc)
      OP_RIGHT: begin
        mul_a = 32'(tmag_r);
        mul_b = distance_per_tick;
      end
      OP_LEFT: begin
        mul_a = 32'(tmag_l);
        mul_b = distance_per_tick;
      end
      OP_TURN: begin
        mul_a = inverse_wheel_base;
        mul_b = TURN_PER_RAD;
      end
      OP_GAIN_LO: begin
        mul_a = centre_mag[31:0];
        mul_b = CORDIC_GAIN_INV;
      end
      OP_GAIN_HI: begin
        mul_a = 32'(centre_mag[DIST_W-1:32]);
        mul_b = CORDIC_GAIN_INV;
      end
      OP_HEAD_00: begin
        mul_a = diff_mag[31:0];
        mul_b = turn_k[31:0];
      end
      OP_HEAD_01: begin
        mul_a = diff_mag[31:0];
        mul_b = 32'(turn_k[61:32]);
      end
      OP_HEAD_10: begin
        mul_a = 32'(diff_mag[DIST_W:32]);
        mul_b = turn_k[31:0];
      end
      OP_HEAD_11: begin
        mul_a = 32'(diff_mag[DIST_W:32]);
        mul_b = 32'(turn_k[61:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The CORDIC starts from the heading reduced to [-pi/4, pi/4) and a
  // quadrant that is folded back in afterwards.
  logic [31:0] head_bias;
  logic [1:0] quad_now;
  logic [31:0] head_res;
  ang_t z0;

  assign head_bias = heading_acc + 32'h2000_0000;
  assign quad_now = head_bias[31:30];
  assign head_res = heading_acc - {quad_now, 30'd0};
  assign z0 = ANG_W'(signed'(head_res));

  logic cordic_start;
  logic cordic_busy;
  logic cordic_done;
  vec_t cx;
  vec_t cy;

  assign cordic_start = (state == S_MUL) && (mc == OP_LAST);

  ddodo_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cordic_start),
    .x0(x0),
    .z0(z0),
    .busy(cordic_busy),
    .done(cordic_done),
    .x_out(cx),
    .y_out(cy)
  );

  // Quadrant fold, scale to Q16.16 and saturating accumulate.
  vec_t dx;
  vec_t dy;
  vec_t dx_q;
  vec_t dy_q;
  logic signed [VEC_W:0] sum_x;
  logic signed [VEC_W:0] sum_y;
  logic signed [31:0] pos_x_next;
  logic signed [31:0] pos_y_next;
  logic [31:0] dang;
  logic [31:0] heading_next;

  always_comb begin
    unique case (quad)
      2'd1: begin
        dx = -cy;
        dy = cx;
      end
      2'd2: begin
        dx = -cx;
        dy = -cy;
      end
      2'd3: begin
        dx = cy;
        dy = -cx;
      end
      default: begin
        dx = cx;
        dy = cy;
      end
    endcase
  end

  assign dx_q = dx >>> 8;
  assign dy_q = dy >>> 8;
  assign sum_x = (VEC_W+1)'(pos_x_acc) + (VEC_W+1)'(dx_q);
  assign sum_y = (VEC_W+1)'(pos_y_acc) + (VEC_W+1)'(dy_q);

  always_comb begin
    if (sum_x > (VEC_W+1)'(64'sd2147483647)) begin
      pos_x_next = 32'sh7FFF_FFFF;
    end else if (sum_x < -(VEC_W+1)'(64'sd2147483648)) begin
      pos_x_next = 32'sh8000_0000;
    end else begin
      pos_x_next = sum_x[31:0];
    end
    if (sum_y > (VEC_W+1)'(64'sd2147483647)) begin
      pos_y_next = 32'sh7FFF_FFFF;
    end else if (sum_y < -(VEC_W+1)'(64'sd2147483648)) begin
      pos_y_next = 32'sh8000_0000;
    end else begin
      pos_y_next = sum_y[31:0];
    end
  end

  assign dang = dist_diff[DIST_W] ? -head_acc80[79:48] : head_acc80[79:48];
  assign heading_next = heading_acc + dang;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_tick <= DIST_PER_TICK_RESET;
      inverse_wheel_base <= INV_WHEEL_BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISTANCE_PER_TICK: distance_per_tick <= cfg_data;
        REG_INVERSE_WHEEL_BASE: inverse_wheel_base <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mc <= '0;
      prev_right <= '0;
      prev_left <= '0;
      pos_x_acc <= '0;
      pos_y_acc <= '0;
      heading_acc <= '0;
      pose.valid <= 1'b0;
    end else begin
      // In the output phase the valid flag is handled below.
      if (pose.valid && pose.ready && (state != S_OUT)) begin
        pose.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cur_right <= sample.right_count;
            cur_left <= sample.left_count;
            mc <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 64'(mul_a) * 64'(mul_b);
          mc <= mc + 1'b1;
          case (mc)
            OP_LEFT: begin
              dist_r <= tick_r[COUNT_BITS-1] ? -{1'b0, prod[63:8]} : {1'b0, prod[63:8]};
            end
            OP_TURN: begin
              dist_l <= tick_l[COUNT_BITS-1] ? -{1'b0, prod[63:8]} : {1'b0, prod[63:8]};
            end
            OP_GAIN_LO: turn_k <= prod[61:0];
            OP_GAIN_HI: x0_lo <= prod[63:32];
            OP_HEAD_00: begin
              x0 <= centre[DIST_W-1] ? -VEC_W'(prod[57:0] + 58'(x0_lo))
                                     : VEC_W'(prod[57:0] + 58'(x0_lo));
            end
            OP_HEAD_01: head_acc80 <= 80'(prod);
            OP_HEAD_10: head_acc80 <= head_acc80 + {prod[47:0], 32'd0};
            OP_HEAD_11: head_acc80 <= head_acc80 + {prod[47:0], 32'd0};
            OP_LAST: begin
              head_acc80 <= head_acc80 + {prod[15:0], 64'd0};
              quad <= quad_now;
              state <= S_ROT;
            end
            default: ;
          endcase
        end
        S_ROT: begin
          if (cordic_done) begin
            pos_x_acc <= pos_x_next;
            pos_y_acc <= pos_y_next;
            heading_acc <= heading_next;
            prev_right <= cur_right;
            prev_left <= cur_left;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!pose.valid || pose.ready) begin
            pose.valid <= 1'b1;
            pose.pose_x <= pos_x_acc;
            pose.pose_y <= pos_y_acc;
            pose.heading_angle <= heading_acc;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The rotator only runs while the block holds an item.
  a_rot_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    cordic_busy |-> (state == S_ROT))
    else $error("rotator busy outside the rotation phase");

  // An accepted item closes the input until its pose is loaded.
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("input still open after an item was accepted");

  // The heading moves only when a rotation finishes.
  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    !cordic_done |=> (heading_acc == $past(heading_acc)))
    else $error("heading changed outside the pose update");

endmodule

// File: rtl/core/ddodo_cordic.sv
// Iterative CORDIC rotator, one micro-rotation per clock cycle.
module ddodo_cordic
  import ddodo_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  vec_t x0,
  input  ang_t z0,
  output logic busy,
  output logic done,
  output vec_t x_out,
  output vec_t y_out
);

  localparam int IW = $clog2(STEPS);

  vec_t x;
  vec_t y;
  ang_t z;
  logic [IW-1:0] step;
  vec_t x_sh;
  vec_t y_sh;
  ang_t atan_v;

  assign x_sh = x >>> step;
  assign y_sh = y >>> step;
  assign atan_v = ANG_W'(atan_entry(5'(step)));
  assign x_out = x;
  assign y_out = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= x0;
        y <= '0;
        z <= z0;
      end else if (busy) begin
        if (!z[ANG_W-1]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_v;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_v;
        end
        if (step == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule
